FILE: design/latc_pkg.sv
// shared types and constants for the local address table classifier
package latc_pkg;

    localparam int ADDR_W = 32;
    localparam int PORT_W = 3;
    localparam int PLEN_W = 6;
    localparam int SEQ_W  = 16;
    localparam int CMD_W  = 2;
    localparam int ST_W   = 3;
    localparam int CLS_W  = 2;

    localparam int IN_CMD_LSB  = 0;
    localparam int IN_ADDR_LSB = IN_CMD_LSB + CMD_W;
    localparam int IN_PORT_LSB = IN_ADDR_LSB + ADDR_W;
    localparam int IN_PLEN_LSB = IN_PORT_LSB + PORT_W;
    localparam int IN_BITS     = IN_PLEN_LSB + PLEN_W;
    localparam int IN_W        = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_BITS = ST_W + CLS_W + 1 + ADDR_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(ADDR_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 2'd0,
        CMD_DEL = 2'd1,
        CMD_CLS = 2'd2,
        CMD_RSV = 2'd3
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_EXISTS   = 3'd1,
        ST_SUBNET   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [CLS_W-1:0] {
        CLS_SELF = 2'd0,
        CLS_LAN  = 2'd1,
        CLS_EXT  = 2'd2
    } t_class;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [SEQ_W-1:0]  seq;
        logic [PLEN_W-1:0] plen;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] addr;
    } t_entry;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic clr_wr;
        logic commit;
    } t_ctl;

    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic logic [ADDR_W-1:0] plen_mask(input logic [PLEN_W-1:0] plen);
        logic [ADDR_W-1:0] m;
        if (plen == '0) begin
            m = '0;
        end else if (plen >= PLEN_MAX) begin
            m = '1;
        end else begin
            m = ~('1 >> plen);
        end
        return m;
    endfunction

endpackage

FILE: design/latc_ram.sv
// generic single write port ram with registered read
module latc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/latc_ctrl.sv
// controller: clearing pass, table scan sequencing and result commit
module latc_ctrl #(
    parameter int ENTRIES = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    input  latc_pkg::t_sts                            i_sts,
    output latc_pkg::t_ctl                            o_ctl,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] o_idx
);
    import latc_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_ctl      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clr_wr = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_ctl.load = 1'b1;
                    n_idx      = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.rd_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_LAST;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_LAST: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idx = r_idx;
endmodule

FILE: design/latc_dp.sv
// datapath: entry table, shared masked comparator, decision and output register
module latc_dp #(
    parameter int ENTRIES = 64,
    parameter int PORTS   = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  latc_pkg::t_ctl                            i_ctl,
    input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] i_idx,
    input  logic [latc_pkg::IN_W-1:0]                 i_s_tdata,
    output latc_pkg::t_sts                            o_sts,
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    output logic [latc_pkg::OUT_W-1:0]                o_m_tdata
);
    import latc_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    // input fields
    t_cmd              f_cmd;
    logic [ADDR_W-1:0] f_addr;
    logic [PORT_W-1:0] f_port;
    logic [PLEN_W-1:0] f_plen;

    assign f_cmd  = t_cmd'(i_s_tdata[IN_CMD_LSB +: CMD_W]);
    assign f_addr = i_s_tdata[IN_ADDR_LSB +: ADDR_W];
    assign f_port = i_s_tdata[IN_PORT_LSB +: PORT_W];
    assign f_plen = i_s_tdata[IN_PLEN_LSB +: PLEN_W];

    // command registers
    t_cmd              r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [PORT_W-1:0] r_port;
    logic [PLEN_W-1:0] r_plen;
    logic              r_port_ok;

    // table bookkeeping
    logic [CW-1:0]    r_count;
    logic [SEQ_W-1:0] r_ins_cnt;

    // scan results
    logic              r_cmp_vld;
    logic              r_lpm_hit;
    logic [PLEN_W-1:0] r_best_len;
    logic [SEQ_W-1:0]  r_best_age;
    logic [ADDR_W-1:0] r_best_addr;
    logic              r_pair_hit;
    logic [IW-1:0]     r_pair_idx;
    logic              r_free_hit;
    logic [IW-1:0]     r_free_idx;
    logic [IW-1:0]     r_cmp_idx;

    // output register
    logic             r_out_vld;
    logic [OUT_W-1:0] r_out_data;

    // memory
    t_entry        w_rd;
    t_entry        w_wdata;
    logic          w_we;
    logic [IW-1:0] w_waddr;

    latc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (i_idx),
        .o_rdata (w_rd)
    );

    // masked compare of one entry
    logic             w_on_port, w_cover, w_better;
    logic [SEQ_W-1:0] w_age;

    assign w_on_port = w_rd.valid && r_port_ok && (w_rd.port == r_port);
    assign w_cover   = w_on_port && (((w_rd.addr ^ r_addr) & plen_mask(w_rd.plen)) == '0);
    assign w_age     = r_ins_cnt - w_rd.seq;
    assign w_better  = !r_lpm_hit || (w_rd.plen > r_best_len) ||
                       ((w_rd.plen == r_best_len) && (w_age < r_best_age));

    // decision
    t_status w_status;
    t_class  w_cls;
    logic    w_add_ok, w_del_ok;

    always_comb begin
        w_status = ST_NOTFOUND;
        w_cls    = CLS_SELF;
        w_add_ok = 1'b0;
        w_del_ok = 1'b0;
        case (r_cmd)
            CMD_ADD: begin
                if (!r_port_ok) begin
                    w_status = ST_NOTFOUND;
                end else if (r_count >= FULL_CNT) begin
                    w_status = ST_FULL;
                end else if ((r_count != '0) && r_lpm_hit && (r_best_len == r_plen)) begin
                    w_status = ST_SUBNET;
                end else if (r_pair_hit) begin
                    w_status = ST_EXISTS;
                end else if (r_free_hit) begin
                    w_status = ST_OK;
                    w_add_ok = 1'b1;
                end else begin
                    w_status = ST_FULL;
                end
            end
            CMD_DEL: begin
                if (r_pair_hit) begin
                    w_status = ST_OK;
                    w_del_ok = 1'b1;
                end
            end
            CMD_CLS: begin
                w_status = ST_OK;
                if (r_pair_hit) begin
                    w_cls = CLS_SELF;
                end else if (r_lpm_hit) begin
                    w_cls = CLS_LAN;
                end else begin
                    w_cls = CLS_EXT;
                end
            end
            default: begin
                w_status = ST_NOTFOUND;
                w_cls    = CLS_EXT;
            end
        endcase
    end

    // write port: clearing pass or commit
    always_comb begin
        w_we    = i_ctl.clr_wr || (i_ctl.commit && (w_add_ok || w_del_ok));
        w_waddr = i_idx;
        w_wdata = '0;
        if (!i_ctl.clr_wr) begin
            if (w_add_ok) begin
                w_waddr       = r_free_idx;
                w_wdata.valid = 1'b1;
                w_wdata.seq   = r_ins_cnt;
                w_wdata.plen  = r_plen;
                w_wdata.port  = r_port;
                w_wdata.addr  = r_addr;
            end else begin
                w_waddr = r_pair_idx;
            end
        end
    end

    assign o_sts.out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd     <= f_cmd;
            r_addr    <= f_addr;
            r_port    <= f_port;
            r_plen    <= (f_plen > PLEN_MAX) ? PLEN_MAX : f_plen;
            r_port_ok <= (32'(f_port) < 32'(PORTS));
        end
        r_cmp_idx <= i_idx;
        if (i_ctl.load) begin
            r_best_addr <= '0;
        end else if (r_cmp_vld && w_cover && w_better) begin
            r_best_len  <= w_rd.plen;
            r_best_age  <= w_age;
            r_best_addr <= w_rd.addr;
        end
        if (r_cmp_vld && w_on_port && !r_pair_hit && (w_rd.addr == r_addr)) begin
            r_pair_idx <= r_cmp_idx;
        end
        if (r_cmp_vld && !w_rd.valid && !r_free_hit) begin
            r_free_idx <= r_cmp_idx;
        end
        if (i_ctl.commit) begin
            r_out_data <= {{(OUT_W - OUT_BITS){1'b0}}, r_best_addr, r_lpm_hit, w_cls, w_status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld  <= 1'b0;
            r_lpm_hit  <= 1'b0;
            r_pair_hit <= 1'b0;
            r_free_hit <= 1'b0;
            r_count    <= '0;
            r_ins_cnt  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_cmp_vld <= i_ctl.rd_en;
            if (i_ctl.load) begin
                r_lpm_hit  <= 1'b0;
                r_pair_hit <= 1'b0;
                r_free_hit <= 1'b0;
            end else if (r_cmp_vld) begin
                if (w_cover) begin
                    r_lpm_hit <= 1'b1;
                end
                if (w_on_port && (w_rd.addr == r_addr)) begin
                    r_pair_hit <= 1'b1;
                end
                if (!w_rd.valid) begin
                    r_free_hit <= 1'b1;
                end
            end
            if (i_ctl.commit && w_add_ok) begin
                r_count   <= r_count + CW'(1);
                r_ins_cnt <= r_ins_cnt + SEQ_W'(1);
            end else if (i_ctl.commit && w_del_ok) begin
                r_count <= r_count - CW'(1);
            end
            if (i_ctl.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above table size");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.commit |-> (!r_out_vld || i_m_tready))
        else $error("result overwrites a pending transfer");

    a_add_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.commit && w_add_ok) |-> (r_free_hit && !r_pair_hit && r_count < FULL_CNT))
        else $error("add without free slot or with duplicate pair");

    a_no_load_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> !i_ctl.load)
        else $error("new command loaded during scan");
endmodule

FILE: design/local_address_table_classifier.sv
// top level of the local address table classifier
//
// Keeps a table of local IPv4 addresses with port and prefix length and runs
// add, delete and classify commands against it.
// Input channel (s): one command per transfer; o_s_tready is high only while
// the block is idle. Output channel (m): one result per command, in order.
// Each command scans every table entry through one shared masked comparator,
// one entry per cycle out of a table memory with one write port and registered
// read. After the scan the result is written to the output register at the
// commit in S_DONE; the next command is taken only once the block is idle again.
// A finished result waits in the output register while the next command is
// taken and scanned; if the receiver still stalls when that command is done,
// the block holds it and accepts nothing more until the result is taken.
// After reset the table memory is cleared in a pass over every entry, during
// which o_s_tready stays low; the table is then empty.
module local_address_table_classifier #(
    parameter int ENTRIES = 64,
    parameter int PORTS   = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // cmd[1:0], addr[33:2], port[36:34], prefix_len[42:37], zero pad
    input  logic [latc_pkg::IN_W-1:0]    i_s_tdata,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // status[2:0], local_class[4:3], subnet_found[5], subnet_addr[37:6], zero pad
    output logic [latc_pkg::OUT_W-1:0]   o_m_tdata
);
    import latc_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_ctl          w_ctl;
    t_sts          w_sts;
    logic [IW-1:0] w_idx;

    latc_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl),
        .o_idx      (w_idx)
    );

    latc_dp #(
        .ENTRIES (ENTRIES),
        .PORTS   (PORTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_idx      (w_idx),
        .i_s_tdata  (i_s_tdata),
        .o_sts      (w_sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );
endmodule
